// ===== sv/sorted_priority_table_insert_macros.svh =====
// Assertion macros for the sorted priority table.
// Used by sorted_priority_table_insert.sv; no other dependencies.
`ifndef SORTED_PRIORITY_TABLE_INSERT_MACROS_SVH
`define SORTED_PRIORITY_TABLE_INSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define SPTI_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define SPTI_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/spti_pkg.sv =====
// Shared types and constants for the sorted priority table.
// No dependencies; imported by spti_cell and sorted_priority_table_insert.
package spti_pkg;

    localparam int VALUE_W   = 32;
    localparam int PRIO_W    = 3;
    localparam int TDATA_W   = 40;
    localparam logic [PRIO_W-1:0] PRIO_NONE = 3'd0;
    localparam logic [PRIO_W-1:0] PRIO_MIN  = 3'd1;
    localparam logic [PRIO_W-1:0] PRIO_MAX  = 3'd5;

    typedef enum logic {
        KIND_INSERT  = 1'b0,
        KIND_READOUT = 1'b1
    } kind_t;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;  // place the new entry
        logic rot;  // rotate stored entries one place toward the head
    } cell_ctrl_t;

endpackage

// ===== sv/spti_cell.sv =====
// One slot of the sorted table: holds an entry, compares it with the new entry
// and takes data from its neighbors on insert or rotate. Depends on spti_pkg.
module spti_cell
    import spti_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cell_ctrl_t               ctrl,
    input  logic signed [VALUE_W-1:0] new_value,
    input  logic [PRIO_W-1:0]        new_prio,
    input  logic signed [VALUE_W-1:0] prev_value,
    input  logic [PRIO_W-1:0]        prev_prio,
    input  logic                     prev_ahead,
    input  logic signed [VALUE_W-1:0] next_value,
    input  logic [PRIO_W-1:0]        next_prio,
    input  logic signed [VALUE_W-1:0] head_value,
    input  logic [PRIO_W-1:0]        head_prio,
    output logic signed [VALUE_W-1:0] value,
    output logic [PRIO_W-1:0]        prio,
    output logic                     ahead,
    output logic                     match
);

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic [PRIO_W-1:0]         prio_reg;
    logic [PRIO_W-1:0]         prio_next;
    logic                      filled;
    logic                      next_filled;

    assign filled      = (prio_reg != PRIO_NONE);
    assign next_filled = (next_prio != PRIO_NONE);

    // New entry belongs at or ahead of this slot
    assign ahead = !filled || (prio_reg < new_prio) ||
                   ((prio_reg == new_prio) && (value_reg >= new_value));
    assign match = filled && (prio_reg == new_prio) && (value_reg == new_value);

    always_comb
    begin
        value_next = value_reg;
        prio_next  = prio_reg;
        if (ctrl.ins && ahead)
        begin
            if (prev_ahead)
            begin
                value_next = prev_value;
                prio_next  = prev_prio;
            end
            else
            begin
                value_next = new_value;
                prio_next  = new_prio;
            end
        end
        else if (ctrl.rot && filled)
        begin
            // Last filled slot wraps around to the head
            if (next_filled)
            begin
                value_next = next_value;
                prio_next  = next_prio;
            end
            else
            begin
                value_next = head_value;
                prio_next  = head_prio;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prio_reg <= PRIO_NONE;
        else
            prio_reg <= prio_next;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign prio  = prio_reg;

endmodule

// ===== sv/sorted_priority_table_insert.sv =====
// Sorted priority table: a chain of CAPACITY cells kept in order (higher priority
// first, ascending signed value within a priority). Insert: no result word. Readout:
// reading_reg is set on the readout, then the first word is registered on m_tvalid;
// then one word per cycle as the chain rotates past cell 0 (n words, one for an empty
// table); input is held off until the last word is registered, and m_tready low stalls
// the rotation. Reset (rst_n, async, active low) empties the table and clears overflow.
`include "sorted_priority_table_insert_macros.svh"

module sorted_priority_table_insert
    import spti_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    // Input stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // [31:0] value, [34:32] priority_req, zero pad
    input  logic [0:0]         s_tuser,   // [0] kind
    // Result stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [31:0] entry_value, [34:32] entry_priority, zero pad
    output logic [1:0]         m_tuser,   // [0] valid_res, [1] overflowed
    output logic               m_tlast
);

    localparam int CW = $clog2(CAPACITY + 1);

    // Input word fields
    logic signed [VALUE_W-1:0] in_value;
    logic [PRIO_W-1:0]         in_prio;
    kind_t                     in_kind;

    assign in_value = s_tdata[VALUE_W-1:0];
    assign in_prio  = s_tdata[VALUE_W +: PRIO_W];
    assign in_kind  = kind_t'(s_tuser[0]);

    // Cell chain wiring
    logic signed [VALUE_W-1:0] cell_value  [CAPACITY];
    logic [PRIO_W-1:0]         cell_prio   [CAPACITY];
    logic [CAPACITY-1:0]       cell_ahead;
    logic [CAPACITY-1:0]       cell_match;
    cell_ctrl_t                ctrl;

    // Control state
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] rem_reg;
    logic [CW-1:0] rem_next;
    logic          reading_reg;
    logic          reading_next;
    logic          ovf_reg;
    logic          ovf_next;

    // Output register
    logic                      m_valid_reg;
    logic                      m_valid_next;
    logic signed [VALUE_W-1:0] m_value_reg;
    logic [PRIO_W-1:0]         m_prio_reg;
    logic                      m_res_reg;
    logic                      m_last_reg;
    logic                      m_ovf_reg;

    logic in_take;
    logic prio_ok;
    logic dup;
    logic full;
    logic ins_ok;
    logic ins_drop;
    logic step;
    logic step_empty;

    assign s_tready = !reading_reg;
    assign in_take  = s_tvalid && s_tready;

    assign prio_ok  = (in_prio >= PRIO_MIN) && (in_prio <= PRIO_MAX);
    assign dup      = |cell_match;
    assign full     = (count_reg == CW'(CAPACITY));
    // Hold the table on a bad priority or a duplicate; drop and flag when full
    assign ins_ok   = in_take && (in_kind == KIND_INSERT) && prio_ok && !dup && !full;
    assign ins_drop = in_take && (in_kind == KIND_INSERT) && prio_ok && !dup && full;

    // Advance the readout whenever the output register is free or being drained
    assign step       = reading_reg && (!m_valid_reg || m_tready);
    assign step_empty = (rem_reg == '0);

    assign ctrl.ins = ins_ok;
    assign ctrl.rot = step && !step_empty;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [VALUE_W-1:0] prev_value;
            logic [PRIO_W-1:0]         prev_prio;
            logic                      prev_ahead;
            logic signed [VALUE_W-1:0] next_value;
            logic [PRIO_W-1:0]         next_prio;

            if (gi == 0)
            begin : g_head
                assign prev_value = in_value;
                assign prev_prio  = in_prio;
                assign prev_ahead = 1'b0;
            end
            else
            begin : g_body
                assign prev_value = cell_value[gi-1];
                assign prev_prio  = cell_prio[gi-1];
                assign prev_ahead = cell_ahead[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign next_value = in_value;
                assign next_prio  = PRIO_NONE;
            end
            else
            begin : g_mid
                assign next_value = cell_value[gi+1];
                assign next_prio  = cell_prio[gi+1];
            end

            spti_cell u_cell
            (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .new_value   (in_value),
                .new_prio    (in_prio),
                .prev_value  (prev_value),
                .prev_prio   (prev_prio),
                .prev_ahead  (prev_ahead),
                .next_value  (next_value),
                .next_prio   (next_prio),
                .head_value  (cell_value[0]),
                .head_prio   (cell_prio[0]),
                .value       (cell_value[gi]),
                .prio        (cell_prio[gi]),
                .ahead       (cell_ahead[gi]),
                .match       (cell_match[gi])
            );
        end
    endgenerate

    // Control next state
    always_comb
    begin
        count_next   = count_reg;
        rem_next     = rem_reg;
        reading_next = reading_reg;
        ovf_next     = ovf_reg || ins_drop;
        m_valid_next = m_valid_reg;

        if (ins_ok)
            count_next = count_reg + CW'(1);

        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;

        if (in_take && (in_kind == KIND_READOUT))
        begin
            reading_next = 1'b1;
            rem_next     = count_reg;
        end
        else if (step)
        begin
            m_valid_next = 1'b1;
            if (step_empty || (rem_reg == CW'(1)))
                reading_next = 1'b0;
            if (!step_empty)
                rem_next = rem_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            rem_reg     <= '0;
            reading_reg <= 1'b0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            rem_reg     <= rem_next;
            reading_reg <= reading_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload: head cell, or the empty marker when the table is empty
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            m_value_reg <= step_empty ? '0 : cell_value[0];
            m_prio_reg  <= step_empty ? PRIO_NONE : cell_prio[0];
            m_res_reg   <= !step_empty;
            m_last_reg  <= step_empty || (rem_reg == CW'(1));
            m_ovf_reg   <= ovf_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(TDATA_W - VALUE_W - PRIO_W){1'b0}}, m_prio_reg, m_value_reg};
    assign m_tuser  = {m_ovf_reg, m_res_reg};
    assign m_tlast  = m_last_reg;

    // Checks
    `SPTI_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(CAPACITY),
        "entry count exceeds capacity")
    `SPTI_ASSERT_NOW(a_empty_head, clk, rst_n, count_reg == '0, cell_prio[0] == PRIO_NONE,
        "empty table holds an entry in the head cell")
    `SPTI_ASSERT_NEXT(a_insert_count, clk, rst_n, ins_ok, count_reg == $past(count_reg) + CW'(1),
        "accepted insert did not grow the table")

endmodule

// ===== sim/sorted_priority_table_insert_tb.sv =====
`timescale 1ns / 100ps
// Testbench for sorted_priority_table_insert: streams insert and readout words,
// keeps its own sorted copy of the table and checks every readout word against it.
// Depends on spti_pkg and the sorted_priority_table_insert RTL.

module sorted_priority_table_insert_tb;
    import spti_pkg::*;

    localparam int CAPACITY     = 32;
    localparam int RANDOM_ITEMS = 420;
    localparam int QUIET_TAIL   = 60;    // last words are sent with no idling on either side
    localparam int DRAIN_CYCLES = 64;
    localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7fff_ffff;

    // One command word as sent on the input stream
    typedef struct packed {
        kind_t              kind;
        logic [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]  prio;
    } cmd_t;

    // One readout word as expected on the result stream
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]  prio;
        logic               valid;
        logic               is_last;
        logic               ovf;
    } entry_word_t;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata  = '0;
    logic [0:0]         s_tuser  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [1:0]         m_tuser;
    logic               m_tlast;

    // Local copy of the sorted table
    logic [VALUE_W-1:0] tbl_value [CAPACITY];
    logic [PRIO_W-1:0]  tbl_prio  [CAPACITY];
    int                 tbl_count    = 0;
    logic               tbl_overflow = 1'b0;

    cmd_t        pending_q[$];     // words still to be sent
    cmd_t        inserted_q[$];    // valid entries queued so far, reused to make duplicates
    entry_word_t expected_q[$];    // readout words still to arrive

    int   total_items = 0;
    int   items_taken = 0;
    int   errors      = 0;
    int   send_gap    = 0;
    int   stall_left  = 0;
    logic word_taken  = 1'b0;      // input word accepted at the last rising edge
    logic idling_on;

    assign idling_on = (items_taken + QUIET_TAIL < total_items);

    sorted_priority_table_insert #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [31:0] value, [34:32] priority_req, zero pad
        .s_tuser  (s_tuser),    // [0] kind
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [31:0] entry_value, [34:32] entry_priority, zero pad
        .m_tuser  (m_tuser),    // [0] valid_res, [1] overflowed
        .m_tlast  (m_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Place one entry in the local table: drop out-of-range priorities and exact
    // duplicates, flag overflow when a new entry does not fit, else shift down.
    task automatic insert_entry(input logic [VALUE_W-1:0] v, input logic [PRIO_W-1:0] p);
        int pos;
        int k;
        pos = 0;
        if (p < PRIO_MIN || p > PRIO_MAX)
            return;
        while (pos < tbl_count)
        begin
            if (tbl_prio[pos] < p)
                break;
            if (tbl_prio[pos] == p && $signed(tbl_value[pos]) >= $signed(v))
                break;
            pos++;
        end
        if (pos < tbl_count && tbl_prio[pos] == p && tbl_value[pos] == v)
            return;
        if (tbl_count >= CAPACITY)
        begin
            tbl_overflow = 1'b1;
            return;
        end
        for (k = tbl_count; k > pos; k--)
        begin
            tbl_value[k] = tbl_value[k-1];
            tbl_prio[k]  = tbl_prio[k-1];
        end
        tbl_value[pos] = v;
        tbl_prio[pos]  = p;
        tbl_count++;
    endtask

    // Queue the words a readout returns: every entry in order, or one empty word.
    task automatic read_out_table();
        entry_word_t w;
        int i;
        if (tbl_count == 0)
        begin
            w.value   = '0;
            w.prio    = PRIO_NONE;
            w.valid   = 1'b0;
            w.is_last = 1'b1;
            w.ovf     = tbl_overflow;
            expected_q.push_back(w);
        end
        else
        begin
            for (i = 0; i < tbl_count; i++)
            begin
                w.value   = tbl_value[i];
                w.prio    = tbl_prio[i];
                w.valid   = 1'b1;
                w.is_last = (i == tbl_count - 1);
                w.ovf     = tbl_overflow;
                expected_q.push_back(w);
            end
        end
    endtask

    task automatic push_insert(input logic [VALUE_W-1:0] v, input logic [PRIO_W-1:0] p);
        cmd_t c;
        c.kind  = KIND_INSERT;
        c.value = v;
        c.prio  = p;
        pending_q.push_back(c);
        if (p >= PRIO_MIN && p <= PRIO_MAX)
            inserted_q.push_back(c);
    endtask

    // The value and priority fields carry noise on a readout; the block ignores them.
    task automatic push_readout();
        cmd_t c;
        c.kind  = KIND_READOUT;
        c.value = $urandom;
        c.prio  = PRIO_W'($urandom_range(0, 7));
        pending_q.push_back(c);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: mismatch on %s, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Stimulus: directed words first, then random insert/readout traffic.
    initial
    begin
        cmd_t               c;
        int                 roll;
        logic [VALUE_W-1:0] v;
        logic [PRIO_W-1:0]  p;

        // empty table, then priorities outside 1..5 must leave it empty
        push_readout();
        push_insert(32'd5, 3'd0);
        push_insert(32'd5, 3'd6);
        push_insert(32'd5, 3'd7);
        push_readout();
        // value extremes, entries at every priority, same value at several priorities
        push_insert(32'd0, 3'd3);
        push_insert(32'hffff_ffff, 3'd3);
        push_insert(VALUE_MAX, 3'd3);
        push_insert(VALUE_MIN, 3'd3);
        push_insert(32'd7, 3'd5);
        push_insert(32'd7, 3'd1);
        push_insert(VALUE_MIN, 3'd5);
        push_insert(VALUE_MAX, 3'd1);
        push_insert(32'd100, 3'd2);
        push_insert(-32'sd100, 3'd4);
        // exact duplicates are dropped, same value at a new priority is kept
        push_insert(32'd0, 3'd3);
        push_insert(32'd7, 3'd5);
        push_insert(32'd100, 3'd4);
        push_readout();
        push_insert(32'hffff_ffff, 3'd7);
        push_readout();

        // Random part: the table only grows, so it fills and overflows early on;
        // duplicates of stored entries keep hitting the duplicate check, not the full-table path.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 30)
                push_readout();
            else if (roll < 62 && inserted_q.size() > 0)
            begin
                c = inserted_q[$urandom_range(0, inserted_q.size() - 1)];
                push_insert(c.value, c.prio);
            end
            else if (roll < 70)
            begin
                case ($urandom_range(0, 2))
                    0: p = PRIO_NONE;
                    1: p = 3'd6;
                    default: p = 3'd7;
                endcase
                push_insert($urandom, p);
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0: v = ($urandom_range(0, 1) == 0) ? VALUE_MIN : VALUE_MAX;
                    1: v = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'hffff_ffff;
                    2, 3: v = $urandom_range(0, 16) - 8;
                    default: v = $urandom;
                endcase
                push_insert(v, PRIO_W'($urandom_range(PRIO_MIN, PRIO_MAX)));
            end
        end
        total_items = pending_q.size();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (!(items_taken == total_items && expected_q.size() == 0))
            @(posedge clk);
        // let any stray result word show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #12_000_000;
        $display("FAIL");
        $finish;
    end

    // Input driver: hold a word until it is taken, then advance or idle a burst.
    always @(negedge clk)
    begin : driver
        cmd_t c;
        if (rst_n)
        begin
            if (!s_tvalid || word_taken)
            begin
                if (send_gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (idling_on && $urandom_range(0, 7) == 0)
                begin
                    s_tvalid <= 1'b0;
                    send_gap <= $urandom_range(0, 14);
                end
                else if (pending_q.size() > 0)
                begin
                    c = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(TDATA_W - PRIO_W - VALUE_W){1'b0}}, c.prio, c.value};
                    s_tuser  <= c.kind;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Result side back-pressure: stall in bursts while idling is on.
    always @(negedge clk)
    begin : receiver
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                m_tready   <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                m_tready   <= 1'b0;
                stall_left <= $urandom_range(0, 14);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Monitor: update the local table on each accepted input word, then check
    // each accepted result word against the oldest expectation.
    always @(posedge clk)
    begin : monitor
        entry_word_t want;
        word_taken <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                items_taken++;
                if (kind_t'(s_tuser[0]) == KIND_READOUT)
                    read_out_table();
                else
                    insert_entry(s_tdata[VALUE_W-1:0], s_tdata[VALUE_W +: PRIO_W]);
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t ns: unexpected result word, expected none, actual %0h",
                             $time, {m_tlast, m_tuser, m_tdata});
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("entry_value", want.value, m_tdata[VALUE_W-1:0]);
                    check_field("entry_priority", 32'(want.prio),
                                32'(m_tdata[VALUE_W +: PRIO_W]));
                    check_field("valid_res", 32'(want.valid), 32'(m_tuser[0]));
                    check_field("last", 32'(want.is_last), 32'(m_tlast));
                    check_field("overflowed", 32'(want.ovf), 32'(m_tuser[1]));
                end
            end
        end
    end

endmodule
